[src/polar_track_derivatives_assert.svh]
// Assertion macros for the track-derivative block.
`ifndef POLAR_TRACK_DERIVATIVES_ASSERT_SVH
`define POLAR_TRACK_DERIVATIVES_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PTD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/ptd_pkg.sv]
`timescale 1ns / 1ps
package ptd_pkg;
    localparam int ROTATION_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_STEPS = (ROTATION_STEPS < ATAN_ENTRIES) ? ROTATION_STEPS
                                                                  : ATAN_ENTRIES;
    localparam int STEP_W = 5;
    localparam int VW = 40;
    localparam int AW = 20;
    localparam logic signed [AW-1:0] PI_Q16 = 20'sd205887;
    localparam logic signed [AW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [19:0] GAIN_Q20 = 20'd636751;
    localparam logic signed [25:0] POS_MAX = 26'sh1FFFFFF;
    localparam logic signed [25:0] POS_MIN = -26'sh2000000;
    localparam int DIV_W = 84;
    localparam int DEN_W = 64;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROT, ST_GAIN, ST_DIFF, ST_DIV, ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    function automatic logic signed [AW-1:0] atan_lut(input logic [STEP_W-1:0] i);
        logic signed [AW-1:0] r;
        r = '0;
        unique case (i)
            5'd0: r = 20'sd51472;
            5'd1: r = 20'sd30386;
            5'd2: r = 20'sd16055;
            5'd3: r = 20'sd8150;
            5'd4: r = 20'sd4091;
            5'd5: r = 20'sd2047;
            5'd6: r = 20'sd1024;
            5'd7: r = 20'sd512;
            5'd8: r = 20'sd256;
            5'd9: r = 20'sd128;
            5'd10: r = 20'sd64;
            5'd11: r = 20'sd32;
            5'd12: r = 20'sd16;
            5'd13: r = 20'sd8;
            5'd14: r = 20'sd4;
            5'd15: r = 20'sd2;
            5'd16: r = 20'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

[src/ptd_divider.sv]
`timescale 1ns / 1ps
module ptd_divider
    import ptd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    output logic              busy,
    output logic [DIV_W-1:0]  quot
);
    logic [DIV_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg;
    logic [6:0]       cnt_reg, cnt_next;
    logic [DEN_W+1:0] trial;
    logic [DEN_W:0]   shifted;

    always_comb
    begin
        shifted = {r_reg[DEN_W-1:0], q_reg[DIV_W-1]};
        trial   = {1'b0, shifted} - {2'b00, d_reg};
        q_next  = q_reg;
        r_next  = r_reg;
        cnt_next = cnt_reg;
        if (req.start)
        begin
            q_next = req.num;
            r_next = '0;
            cnt_next = 7'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 7'd1;
            if (!trial[DEN_W+1])
            begin
                r_next = trial[DEN_W:0];
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (req.start)
            d_reg <= req.den;
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
endmodule

[src/polar_track_derivatives.sv]
`timescale 1ns / 1ps
// Polar-to-cartesian converter with central-difference derivatives.
// Input channel: sample_time, bearing, distance with in_valid / in_stall.
// Output channel: pos_x, pos_y, deriv_valid, vel_x, vel_y, acc_x, acc_y,
// zero_step with out_valid / out_stall; one result per request.
// One request at a time: a CORDIC of 16 rotation steps on a shared
// add/shift unit, two gain multiplies, then, once three samples are held,
// four serial divisions on one restoring divider (84 steps each), skipped
// when the time step is zero.
// in_stall is high from the cycle after acceptance until the result is
// taken, so a new request may enter in the cycle in which out_valid falls.
// Reset clears the window (fill count and positions) and the sequencer.
// While out_stall is high the result is held unchanged.
module polar_track_derivatives
    import ptd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         sample_time,
    input  logic signed [17:0]  bearing,
    input  logic [23:0]         distance,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [25:0]  pos_x,
    output logic signed [25:0]  pos_y,
    output logic                deriv_valid,
    output logic [31:0]         vel_x,
    output logic [31:0]         vel_y,
    output logic signed [31:0]  acc_x,
    output logic signed [31:0]  acc_y,
    output logic                zero_step
);
    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [1:0] div_idx_reg;
    logic div_wait_reg;
    logic signed [VW-1:0] x_reg, y_reg;
    logic signed [AW-1:0] a_reg;
    logic flip_reg;
    logic [31:0] time_reg;
    logic signed [25:0] older_x_reg, older_y_reg, middle_x_reg, middle_y_reg;
    logic [31:0] middle_time_reg;
    logic [1:0] fill_reg;
    logic [31:0] h_reg;
    logic [63:0] h2_reg;
    logic [27:0] dvx_reg, dvy_reg, sx_reg, sy_reg;
    logic dvx_s_reg, dvy_s_reg, sx_s_reg, sy_s_reg;
    logic signed [25:0] px_reg, py_reg;
    logic dv_reg, zs_reg;
    logic [31:0] vx_reg, vy_reg, ax_reg, ay_reg;
    logic gain_sel_reg;

    div_req_t div_req;
    logic div_busy;
    logic [DIV_W-1:0] div_q;

    ptd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quot  (div_q)
    );

    logic accept;
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);

    logic signed [VW-1:0] xs, ys;
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;

    // gain multiply, one coordinate per cycle
    logic signed [VW-1:0] gsrc;
    logic signed [VW+21:0] gprod;
    logic signed [VW+21:0] gsh;
    logic signed [VW+21:0] gval;
    logic signed [25:0] gsat;
    always_comb
    begin
        gsrc  = gain_sel_reg ? y_reg : x_reg;
        gprod = gsrc * $signed({1'b0, GAIN_Q20}) + (62'sd1 <<< 27);
        gsh   = gprod >>> 28;
        gval  = flip_reg ? -gsh : gsh;
        if (gval > 62'(POS_MAX))
            gsat = POS_MAX;
        else if (gval < 62'(POS_MIN))
            gsat = POS_MIN;
        else
            gsat = gval[25:0];
    end

    // division operand and result selection
    logic [27:0] cur_m;
    logic cur_s;
    logic [DIV_W-1:0] num_sel;
    logic [DEN_W-1:0] den_sel;
    always_comb
    begin
        cur_m = dvx_reg;
        cur_s = dvx_s_reg;
        unique case (div_idx_reg)
            2'd0: begin cur_m = dvx_reg; cur_s = dvx_s_reg; end
            2'd1: begin cur_m = dvy_reg; cur_s = dvy_s_reg; end
            2'd2: begin cur_m = sx_reg; cur_s = sx_s_reg; end
            default: begin cur_m = sy_reg; cur_s = sy_s_reg; end
        endcase
        if (div_idx_reg[1])
        begin
            num_sel = DIV_W'({cur_m, 20'd0});
            den_sel = h2_reg;
        end
        else
        begin
            num_sel = DIV_W'({cur_m, 11'd0});
            den_sel = DEN_W'(h_reg);
        end
    end

    logic [31:0] res_val;
    always_comb
    begin
        if (!div_idx_reg[1])
        begin
            if (h_reg == '0)
                res_val = (cur_m != '0) ? 32'hFFFFFFFF : 32'd0;
            else
                res_val = (div_q > DIV_W'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : div_q[31:0];
        end
        else if (h_reg == '0)
            res_val = (cur_m == '0) ? 32'd0 : (cur_s ? 32'h80000000 : 32'h7FFFFFFF);
        else if (!cur_s)
            res_val = (div_q > DIV_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : div_q[31:0];
        else
            res_val = (div_q > DIV_W'(32'h80000000)) ? 32'h80000000 : (32'd0 - div_q[31:0]);
    end

    logic skip_div;
    assign skip_div = (h_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        div_req.start = 1'b0;
        div_req.num = num_sel;
        div_req.den = den_sel;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_ROT;
            ST_ROT:
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = ST_GAIN;
            ST_GAIN:
                if (gain_sel_reg)
                    state_next = (fill_reg == 2'd2) ? ST_DIFF : ST_DONE;
            ST_DIFF:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (!div_wait_reg && !skip_div)
                    div_req.start = 1'b1;
                else if ((div_wait_reg && !div_busy) || skip_div)
                begin
                    if (div_idx_reg == 2'd3)
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
                if (!out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    logic signed [AW-1:0] a_in;
    logic signed [26:0] dx, dy;
    logic signed [27:0] s_x, s_y;
    logic [31:0] h_abs;
    always_comb
    begin
        a_in = AW'(bearing) <<< 1;
        dx = 27'(px_reg) - 27'(older_x_reg);
        dy = 27'(py_reg) - 27'(older_y_reg);
        s_x = 28'(px_reg) - (28'(middle_x_reg) <<< 1) + 28'(older_x_reg);
        s_y = 28'(py_reg) - (28'(middle_y_reg) <<< 1) + 28'(older_y_reg);
        h_abs = (middle_time_reg >= time_reg) ? (middle_time_reg - time_reg)
                                              : (time_reg - middle_time_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_x_reg <= '0;
            older_y_reg <= '0;
            middle_x_reg <= '0;
            middle_y_reg <= '0;
            middle_time_reg <= '0;
            fill_reg <= '0;
            step_reg <= '0;
            gain_sel_reg <= 1'b0;
            div_idx_reg <= '0;
            div_wait_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    gain_sel_reg <= 1'b0;
                    div_idx_reg <= '0;
                    div_wait_reg <= 1'b0;
                end
                ST_ROT:
                    step_reg <= step_reg + STEP_W'(1);
                ST_GAIN:
                    gain_sel_reg <= 1'b1;
                ST_DIV:
                begin
                    if (!div_wait_reg && !skip_div)
                        div_wait_reg <= 1'b1;
                    else if ((div_wait_reg && !div_busy) || skip_div)
                    begin
                        div_wait_reg <= 1'b0;
                        div_idx_reg <= div_idx_reg + 2'd1;
                    end
                end
                ST_DONE:
                    if (!out_stall)
                    begin
                        older_x_reg <= middle_x_reg;
                        older_y_reg <= middle_y_reg;
                        middle_x_reg <= px_reg;
                        middle_y_reg <= py_reg;
                        middle_time_reg <= time_reg;
                        if (fill_reg != 2'd2)
                            fill_reg <= fill_reg + 2'd1;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    time_reg <= sample_time;
                    x_reg <= VW'({distance, 8'd0});
                    y_reg <= '0;
                    dv_reg <= 1'b0;
                    zs_reg <= 1'b0;
                    vx_reg <= '0;
                    vy_reg <= '0;
                    ax_reg <= '0;
                    ay_reg <= '0;
                    if (a_in > HALF_PI_Q16)
                    begin
                        a_reg <= a_in - PI_Q16;
                        flip_reg <= 1'b1;
                    end
                    else if (a_in < -HALF_PI_Q16)
                    begin
                        a_reg <= a_in + PI_Q16;
                        flip_reg <= 1'b1;
                    end
                    else
                    begin
                        a_reg <= a_in;
                        flip_reg <= 1'b0;
                    end
                end
            ST_ROT:
                if (!a_reg[AW-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    a_reg <= a_reg - atan_lut(step_reg);
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    a_reg <= a_reg + atan_lut(step_reg);
                end
            ST_GAIN:
                if (gain_sel_reg)
                    py_reg <= gsat;
                else
                    px_reg <= gsat;
            ST_DIFF:
            begin
                dv_reg <= 1'b1;
                h_reg <= h_abs;
                h2_reg <= 64'(h_abs) * 64'(h_abs);
                zs_reg <= (h_abs == '0);
                dvx_s_reg <= dx[26];
                dvy_s_reg <= dy[26];
                dvx_reg <= 28'(dx[26] ? -dx : dx);
                dvy_reg <= 28'(dy[26] ? -dy : dy);
                sx_s_reg <= s_x[27];
                sy_s_reg <= s_y[27];
                sx_reg <= s_x[27] ? -s_x : s_x;
                sy_reg <= s_y[27] ? -s_y : s_y;
            end
            ST_DIV:
                if ((div_wait_reg && !div_busy) || skip_div)
                begin
                    unique case (div_idx_reg)
                        2'd0: vx_reg <= res_val;
                        2'd1: vy_reg <= res_val;
                        2'd2: ax_reg <= res_val;
                        default: ay_reg <= res_val;
                    endcase
                end
            default: ;
        endcase
    end

    assign pos_x = px_reg;
    assign pos_y = py_reg;
    assign deriv_valid = dv_reg;
    assign vel_x = vx_reg;
    assign vel_y = vy_reg;
    assign acc_x = ax_reg;
    assign acc_y = ay_reg;
    assign zero_step = zs_reg;

`include "polar_track_derivatives_assert.svh"
    `PTD_ASSERT_IMP(a_stall_busy, state_reg != ST_IDLE, in_stall)
    `PTD_ASSERT_IMP(a_zero_no_div, state_reg == ST_DIV && h_reg == '0, !div_req.start)
    `PTD_ASSERT_NEXT(a_done_hold, out_valid && out_stall, out_valid && $stable(vel_x))
    `PTD_ASSERT_IMP(a_fill_range, 1'b1, fill_reg != 2'd3)
endmodule

[tb/tb_polar_track_derivatives.sv]
`timescale 1ns / 1ps

class track_scoreboard;
    typedef struct packed {
        logic signed [25:0] px;
        logic signed [25:0] py;
        logic               dv;
        logic [31:0]        vx;
        logic [31:0]        vy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic               zs;
    } track_result_t;

    track_result_t pending[$];
    longint older_x, older_y, middle_x, middle_y;
    bit [31:0] middle_time;
    int fill_count;
    int errors;

    function new();
        older_x = 0; older_y = 0; middle_x = 0; middle_y = 0;
        middle_time = 0; fill_count = 0; errors = 0;
    endfunction

    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    static function longint clamp_pos(longint v);
        if (v > 33554431) return 33554431;
        if (v < -33554432) return -33554432;
        return v;
    endfunction

    static function void rotate(longint b, longint d, output longint px, output longint py);
        longint ang, x, y, nx, atan_tab[24];
        bit flip;
        atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128, 64, 32,
                     16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
        ang = b * 2;
        x = d * 256;
        y = 0;
        flip = 0;
        if (ang > 102944) begin ang -= 205887; flip = 1; end
        else if (ang < -102944) begin ang += 205887; flip = 1; end
        for (int i = 0; i < ptd_pkg::ROTATION_STEPS && i < 24; i++)
        begin
            if (ang >= 0)
            begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                ang -= atan_tab[i];
            end
            else
            begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                ang += atan_tab[i];
            end
            x = nx;
        end
        x = floor_shift(x * 636751 + (64'sd1 <<< 27), 28);
        y = floor_shift(y * 636751 + (64'sd1 <<< 27), 28);
        if (flip) begin x = -x; y = -y; end
        px = clamp_pos(x);
        py = clamp_pos(y);
    endfunction

    static function bit [31:0] speed(longint dd, longint unsigned h);
        longint unsigned m, q;
        m = dd < 0 ? -dd : dd;
        if (h == 0) return m != 0 ? 32'hFFFFFFFF : 0;
        q = (m << 11) / h;
        return q > 64'hFFFFFFFF ? 32'hFFFFFFFF : q[31:0];
    endfunction

    static function bit [31:0] curvature(longint s, longint unsigned h);
        longint unsigned m, q;
        m = s < 0 ? -s : s;
        if (h == 0)
        begin
            if (m == 0) return 0;
            return s > 0 ? 32'h7FFFFFFF : 32'h80000000;
        end
        q = (m << 20) / (h * h);
        if (s >= 0) return q > 64'h7FFFFFFF ? 32'h7FFFFFFF : q[31:0];
        if (q > 64'h80000000) q = 64'h80000000;
        q = 0 - q;
        return q[31:0];
    endfunction

    function void note_sample(bit [31:0] t, logic signed [17:0] b, bit [23:0] d);
        track_result_t r;
        longint px, py;
        longint unsigned h;
        rotate(longint'(b), longint'(d), px, py);
        r = '{px[25:0], py[25:0], 1'b0, 32'd0, 32'd0, 32'sd0, 32'sd0, 1'b0};
        if (fill_count >= 2)
        begin
            h = middle_time >= t ? middle_time - t : t - middle_time;
            r.dv = 1'b1;
            r.vx = speed(px - older_x, h);
            r.vy = speed(py - older_y, h);
            r.ax = curvature(px - 2 * middle_x + older_x, h);
            r.ay = curvature(py - 2 * middle_y + older_y, h);
            r.zs = h == 0;
        end
        older_x = middle_x; older_y = middle_y;
        middle_x = px; middle_y = py;
        middle_time = t;
        if (fill_count < 2) fill_count++;
        pending.insert(pending.size(), r);
    endfunction

    function void check_result(track_result_t got);
        track_result_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result px=%0d py=%0d", $time, got.px, got.py);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got !== e)
        begin
            $display("%0t: mismatch exp px=%0d py=%0d dv=%0d vx=%0d vy=%0d ax=%0d ay=%0d zs=%0d",
                     $time, e.px, e.py, e.dv, e.vx, e.vy, e.ax, e.ay, e.zs);
            $display("%0t:          got px=%0d py=%0d dv=%0d vx=%0d vy=%0d ax=%0d ay=%0d zs=%0d",
                     $time, got.px, got.py, got.dv, got.vx, got.vy, got.ax, got.ay, got.zs);
            errors++;
        end
    endfunction
endclass

module tb_polar_track_derivatives;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        sample_time;
    logic signed [17:0] bearing;
    logic [23:0]        distance;
    logic               out_valid;
    logic               out_stall;
    logic signed [25:0] pos_x;
    logic signed [25:0] pos_y;
    logic               deriv_valid;
    logic [31:0]        vel_x;
    logic [31:0]        vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic               zero_step;

    track_scoreboard board;
    int  send_idle_pct;
    int  stall_pct;
    bit [31:0] clock_s;

    polar_track_derivatives i_dut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #20000000;
        $display("FAIL polar_track_derivatives");
        $finish;
    end

    task automatic send_sample(bit [31:0] t, logic signed [17:0] b, bit [23:0] d);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        sample_time <= t;
        bearing <= b;
        distance <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_sample(t, b, d);
        @(negedge clk);
    endtask

    task automatic send_random(int n);
        logic signed [17:0] b;
        bit [31:0] step;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: b = 18'($urandom);
                1: b = $urandom_range(1) ? 18'sh1FFFF : -18'sh20000;
                default: b = $signed(18'($urandom_range(102944))) - 18'sd51472;
            endcase
            case ($urandom_range(9))
                0: step = 0;
                1: step = $urandom;
                2: step = $urandom_range(3);
                default: step = $urandom_range(4096, 1);
            endcase
            clock_s = $urandom_range(3) == 0 ? clock_s - step : clock_s + step;
            send_sample(clock_s, b,
                        $urandom_range(4) == 0 ? 24'($urandom) : 24'($urandom_range(65535)));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result('{pos_x, pos_y, deriv_valid, vel_x, vel_y, acc_x, acc_y,
                                 zero_step});
    end

    always @(negedge clk)
        out_stall <= stall_pct > 0 && $urandom_range(99) < stall_pct;

    initial
    begin
        board = new();
        rst_n = 0;
        in_valid = 0;
        sample_time = 0;
        bearing = 0;
        distance = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        clock_s = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_sample(32'd0, 18'sd0, 24'd0);
        send_sample(32'd256, 18'sh1FFFF, 24'hFFFFFF);
        send_sample(32'd512, -18'sh20000, 24'hFFFFFF);
        send_sample(32'd512, 18'sd25736, 24'd1000);
        send_sample(32'd512, -18'sd25736, 24'hFFFFFF);
        send_sample(32'd100, 18'sd51472, 24'd500);
        send_sample(32'hFFFFFFFF, 18'sd51473, 24'd12345);
        send_sample(32'd0, -18'sd51473, 24'hFFFFFF);
        send_sample(32'd1, 18'sd0, 24'd0);
        send_sample(32'd2, 18'sd0, 24'hFFFFFF);
        send_sample(32'd3, 18'sd102943, 24'h800000);
        send_sample(32'h80000000, -18'sd1, 24'd1);
        send_sample(32'h80000000, 18'sd1, 24'd16);
        send_sample(32'h7FFFFFFF, 18'sh15555, 24'h2AAAAA);

        send_idle_pct = 0;  stall_pct = 0;  send_random(210);
        send_idle_pct = 69; stall_pct = 0;  send_random(210);
        send_idle_pct = 0;  stall_pct = 69; send_random(210);
        send_idle_pct = 25; stall_pct = 25; send_random(210);

        in_valid <= 0;
        while (board.pending.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (board.errors == 0)
            $display("PASS polar_track_derivatives");
        else
            $display("FAIL polar_track_derivatives");
        $finish;
    end
endmodule

[filelist.f]
+incdir+src
src/ptd_pkg.sv
src/ptd_divider.sv
src/polar_track_derivatives.sv
tb/tb_polar_track_derivatives.sv
